### rtl/sclru_pkg.sv
// Shared types and codes for the size-class slot cache.
package sclru_pkg;

    localparam int POOL_CNT = 3;
    localparam int POOL_MAX = 16;
    localparam int IDX_W    = 4;
    localparam int POOL_W   = 2;
    localparam int ADDR_W   = POOL_W + IDX_W;
    localparam int DEPTH    = POOL_CNT * POOL_MAX;
    localparam int BYTES_W  = 24;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ABORT   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] POOL_SMALL  = 2'd0;
    localparam logic [1:0] POOL_MEDIUM = 2'd1;
    localparam logic [1:0] POOL_LARGE  = 2'd2;
    localparam logic [1:0] POOL_NONE   = 2'd3;

    localparam logic [1:0] REG_SMALL_CAP  = 2'd0;
    localparam logic [1:0] REG_MEDIUM_CAP = 2'd1;
    localparam logic [1:0] REG_LARGE_CAP  = 2'd2;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_NO_SLOT  = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;
    localparam logic [2:0] ST_BAD      = 3'd5;

    typedef struct packed {
        logic [31:0]        key;
        logic [7:0]         refs;
        logic [31:0]        last_use;
        logic [BYTES_W-1:0] bytes;
    } entry_t;

endpackage

### rtl/sclru_slot_ram.sv
// Slot entry memory: one write port, one registered read port.
module sclru_slot_ram (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [sclru_pkg::ADDR_W-1:0] waddr,
    input  sclru_pkg::entry_t           wdata,
    input  logic [sclru_pkg::ADDR_W-1:0] raddr,
    output sclru_pkg::entry_t           rdata
);

    sclru_pkg::entry_t mem [sclru_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/size_class_refcount_lru_slot_cache_top.sv
// Top level of the size-class reference-counted LRU slot cache.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_valid / s_ready    opcode, key, geometry, time, handle
// m_       out  m_valid / m_ready    status, slot, bytes, evicted, refcount
// cfg_     in   cfg_valid / cfg_ready  cfg_index (0..2), cfg_data (24b capacity)
//
// Flow: an acquire streams every slot of all three pools through one compare
// stage, one slot per cycle, then drains and decides; release, abort and a bad
// handle read the named slot and answer. The single read port of the slot
// memory sets the scan pace.
// Reset clears the valid bits and control and loads default capacities; no clearing pass.
// A stalled result holds the block in its final state; cfg is always ready.
module size_class_refcount_lru_slot_cache_top #(
    parameter int SMALL_SLOTS  = 16,
    parameter int MEDIUM_SLOTS = 8,
    parameter int LARGE_SLOTS  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_object_key,
    input  logic [7:0]  s_frame_width,
    input  logic [7:0]  s_frame_count,
    input  logic [31:0] s_now_us,
    input  logic [1:0]  s_handle_pool,
    input  logic [3:0]  s_handle_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_result_pool,
    output logic [3:0]  m_result_index,
    output logic [23:0] m_data_bytes,
    output logic        m_evicted,
    output logic [7:0]  m_ref_count_now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int PC = sclru_pkg::POOL_CNT;
    localparam logic [3:0] LAST_S = 4'(SMALL_SLOTS - 1);
    localparam logic [3:0] LAST_M = 4'(MEDIUM_SLOTS - 1);
    localparam logic [3:0] LAST_L = 4'(LARGE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_HREAD, S_HOP, S_BAD
    } state_t;

    function automatic logic [3:0] last_idx(input logic [1:0] p);
        logic [3:0] r;
        case (p)
            sclru_pkg::POOL_SMALL:  r = LAST_S;
            sclru_pkg::POOL_MEDIUM: r = LAST_M;
            default:                r = LAST_L;
        endcase
        return r;
    endfunction

    state_t      state_reg;
    logic [1:0]  op_reg;
    logic [31:0] key_reg;
    logic [7:0]  w_reg;
    logic [7:0]  cnt_reg;
    logic [31:0] now_reg;
    logic [1:0]  hp_reg;
    logic [3:0]  hi_reg;
    logic [15:0] prod_reg;
    logic [23:0] need_reg;
    logic [23:0] cap_reg [PC];

    // scan pointer and compare-stage tag
    logic [1:0]  ptr_pool_reg;
    logic [3:0]  ptr_idx_reg;
    logic        rd_v_reg;
    logic [1:0]  rd_pool_reg;
    logic [3:0]  rd_idx_reg;

    // scan results: hit, and per-pool free slot and LRU candidate
    logic              hit_found_reg;
    logic [1:0]        hit_pool_reg;
    logic [3:0]        hit_idx_reg;
    sclru_pkg::entry_t hit_entry_reg;
    logic [PC-1:0]     free_found_reg;
    logic [3:0]        free_idx_reg [PC];
    logic [PC-1:0]     cand_found_reg;
    logic [3:0]        cand_idx_reg [PC];
    logic [31:0]       oldest_reg [PC];

    logic [sclru_pkg::DEPTH-1:0] valid_reg;

    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [1:0]  m_pool_reg;
    logic [3:0]  m_index_reg;
    logic [23:0] m_bytes_reg;
    logic        m_evicted_reg;
    logic [7:0]  m_refs_reg;

    logic                         ram_we;
    logic [sclru_pkg::ADDR_W-1:0] ram_waddr;
    sclru_pkg::entry_t            ram_wdata;
    logic [sclru_pkg::ADDR_W-1:0] ram_raddr;
    sclru_pkg::entry_t            ram_rdata;

    logic        out_free;
    logic        accept;
    logic        bad_handle;
    logic        rd_slot_valid;
    logic        h_slot_valid;
    logic [7:0]  rel_refs;
    logic [7:0]  hit_refs;
    logic        pick_found;
    logic [1:0]  pick_pool;
    logic [3:0]  pick_idx;
    logic        pick_evict;
    logic [PC-1:0] fit;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign bad_handle = (op_reg == sclru_pkg::OP_UNUSED) || (hp_reg == sclru_pkg::POOL_NONE)
                        || (hi_reg > last_idx(hp_reg));

    assign rd_slot_valid = valid_reg[{rd_pool_reg, rd_idx_reg}];
    assign h_slot_valid  = valid_reg[{hp_reg, hi_reg}];
    assign rel_refs = (ram_rdata.refs == 8'd0) ? 8'd0 : ram_rdata.refs - 8'd1;
    assign hit_refs = (hit_entry_reg.refs == 8'hFF) ? 8'hFF : hit_entry_reg.refs + 8'd1;

    assign ram_raddr = (state_reg == S_SCAN) ? {ptr_pool_reg, ptr_idx_reg} : {hp_reg, hi_reg};

    // first fitting pool (small first) that has a free or evictable slot
    always_comb begin
        pick_found = 1'b0;
        pick_pool  = sclru_pkg::POOL_SMALL;
        pick_idx   = 4'd0;
        pick_evict = 1'b0;
        for (int p = PC - 1; p >= 0; p--) begin
            fit[p] = (need_reg <= cap_reg[p]);
            if (fit[p] && (free_found_reg[p] || cand_found_reg[p])) begin
                pick_found = 1'b1;
                pick_pool  = 2'(p);
                pick_idx   = free_found_reg[p] ? free_idx_reg[p] : cand_idx_reg[p];
                pick_evict = !free_found_reg[p];
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {hp_reg, hi_reg};
        ram_wdata = ram_rdata;
        case (state_reg)
            S_DECIDE: begin
                if (out_free && hit_found_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = {hit_pool_reg, hit_idx_reg};
                    ram_wdata = hit_entry_reg;
                    ram_wdata.refs     = hit_refs;
                    ram_wdata.last_use = now_reg;
                end else if (out_free && pick_found) begin
                    ram_we    = 1'b1;
                    ram_waddr = {pick_pool, pick_idx};
                    ram_wdata.key      = key_reg;
                    ram_wdata.refs     = 8'd1;
                    ram_wdata.last_use = now_reg;
                    ram_wdata.bytes    = need_reg;
                end
            end
            S_HOP: begin
                if (out_free && op_reg == sclru_pkg::OP_RELEASE) begin
                    ram_we         = h_slot_valid;
                    ram_wdata.refs = rel_refs;
                end else if (out_free) begin
                    ram_we             = 1'b1;
                    ram_wdata.key      = 32'd0;
                    ram_wdata.refs     = 8'd0;
                    ram_wdata.last_use = 32'd0;
                end
            end
            default: ;
        endcase
    end

    sclru_slot_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        // need = w*w*cnt, registered through prod_reg and then need_reg
        prod_reg <= 16'(w_reg * w_reg);
        need_reg <= 24'(prod_reg * cnt_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_reg <= 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                sclru_pkg::REG_SMALL_CAP:  cap_reg[0] <= cfg_data;
                sclru_pkg::REG_MEDIUM_CAP: cap_reg[1] <= cfg_data;
                sclru_pkg::REG_LARGE_CAP:  cap_reg[2] <= cfg_data;
                default: ;
            endcase
        end

        // compare stage: one slot per cycle through the shared comparator
        if (rd_v_reg) begin
            if (rd_slot_valid && ram_rdata.key == key_reg && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
                hit_pool_reg  <= rd_pool_reg;
                hit_idx_reg   <= rd_idx_reg;
                hit_entry_reg <= ram_rdata;
            end
            if (!rd_slot_valid && !free_found_reg[rd_pool_reg]) begin
                free_found_reg[rd_pool_reg] <= 1'b1;
                free_idx_reg[rd_pool_reg]   <= rd_idx_reg;
            end
            if (rd_slot_valid && ram_rdata.refs == 8'd0
                && ram_rdata.last_use < oldest_reg[rd_pool_reg]) begin
                oldest_reg[rd_pool_reg]     <= ram_rdata.last_use;
                cand_found_reg[rd_pool_reg] <= 1'b1;
                cand_idx_reg[rd_pool_reg]   <= rd_idx_reg;
            end
        end
        rd_v_reg    <= (state_reg == S_SCAN);
        rd_pool_reg <= ptr_pool_reg;
        rd_idx_reg  <= ptr_idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_reg  <= s_opcode;
                    key_reg <= s_object_key;
                    w_reg   <= s_frame_width;
                    cnt_reg <= s_frame_count;
                    now_reg <= s_now_us;
                    hp_reg  <= s_handle_pool;
                    hi_reg  <= s_handle_index;
                    ptr_pool_reg   <= sclru_pkg::POOL_SMALL;
                    ptr_idx_reg    <= 4'd0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= '0;
                    cand_found_reg <= '0;
                    for (int p = 0; p < PC; p++) begin
                        oldest_reg[p] <= 32'hFFFF_FFFF;
                    end
                    state_reg <= (s_opcode == sclru_pkg::OP_ACQUIRE) ? S_SCAN : S_HREAD;
                end
            end
            S_SCAN: begin
                if (ptr_idx_reg == last_idx(ptr_pool_reg)) begin
                    ptr_idx_reg <= 4'd0;
                    if (ptr_pool_reg == sclru_pkg::POOL_LARGE) begin
                        state_reg <= S_DRAIN;
                    end else begin
                        ptr_pool_reg <= ptr_pool_reg + 2'd1;
                    end
                end else begin
                    ptr_idx_reg <= ptr_idx_reg + 4'd1;
                end
            end
            S_DRAIN: begin
                state_reg <= S_DECIDE;
            end
            S_DECIDE: begin
                if (out_free) begin
                    m_valid_reg   <= 1'b1;
                    m_evicted_reg <= 1'b0;
                    if (hit_found_reg) begin
                        m_status_reg <= sclru_pkg::ST_HIT;
                        m_pool_reg   <= hit_pool_reg;
                        m_index_reg  <= hit_idx_reg;
                        m_bytes_reg  <= hit_entry_reg.bytes;
                        m_refs_reg   <= hit_refs;
                    end else if (pick_found) begin
                        m_status_reg  <= sclru_pkg::ST_NEW;
                        m_pool_reg    <= pick_pool;
                        m_index_reg   <= pick_idx;
                        m_bytes_reg   <= need_reg;
                        m_evicted_reg <= pick_evict;
                        m_refs_reg    <= 8'd1;
                        valid_reg[{pick_pool, pick_idx}] <= 1'b1;
                    end else begin
                        m_status_reg <= sclru_pkg::ST_NO_SLOT;
                        m_pool_reg   <= sclru_pkg::POOL_SMALL;
                        m_index_reg  <= 4'd0;
                        m_bytes_reg  <= need_reg;
                        m_refs_reg   <= 8'd0;
                    end
                    state_reg <= S_IDLE;
                end
            end
            S_HREAD: begin
                state_reg <= bad_handle ? S_BAD : S_HOP;
            end
            S_HOP: begin
                if (out_free) begin
                    m_valid_reg   <= 1'b1;
                    m_pool_reg    <= hp_reg;
                    m_index_reg   <= hi_reg;
                    m_evicted_reg <= 1'b0;
                    if (op_reg == sclru_pkg::OP_RELEASE) begin
                        m_status_reg <= sclru_pkg::ST_RELEASED;
                        m_bytes_reg  <= h_slot_valid ? ram_rdata.bytes : 24'd0;
                        m_refs_reg   <= h_slot_valid ? rel_refs : 8'd0;
                    end else begin
                        m_status_reg <= sclru_pkg::ST_CLEARED;
                        m_bytes_reg  <= 24'd0;
                        m_refs_reg   <= 8'd0;
                        valid_reg[{hp_reg, hi_reg}] <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
            end
            S_BAD: begin
                if (out_free) begin
                    m_valid_reg   <= 1'b1;
                    m_status_reg  <= sclru_pkg::ST_BAD;
                    m_pool_reg    <= hp_reg;
                    m_index_reg   <= hi_reg;
                    m_bytes_reg   <= 24'd0;
                    m_evicted_reg <= 1'b0;
                    m_refs_reg    <= 8'd0;
                    state_reg     <= S_IDLE;
                end
            end
            default: state_reg <= S_IDLE;
        endcase

        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
            valid_reg   <= '0;
            cap_reg[0]  <= 24'd4096;
            cap_reg[1]  <= 24'd16384;
            cap_reg[2]  <= 24'd57600;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_pool   = m_pool_reg;
    assign m_result_index  = m_index_reg;
    assign m_data_bytes    = m_bytes_reg;
    assign m_evicted       = m_evicted_reg;
    assign m_ref_count_now = m_refs_reg;

endmodule

### rtl/sclru_checker.sv
// Port-level checks for the slot cache, bound to the top level.
module sclru_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [23:0] m_data_bytes,
    input logic        m_evicted,
    input logic [7:0]  m_ref_count_now
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_ref_count_now))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a request while busy");

    a_new_one_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == sclru_pkg::ST_NEW |-> m_ref_count_now == 8'd1)
        else $error("new slot without single reference");

    a_evict_only_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> m_status == sclru_pkg::ST_NEW)
        else $error("eviction flag on non-allocation");

    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == sclru_pkg::ST_CLEARED || m_status == sclru_pkg::ST_BAD)
        |-> m_ref_count_now == 8'd0 && m_data_bytes == 24'd0)
        else $error("clear or bad handle result not zero");

endmodule

bind size_class_refcount_lru_slot_cache_top sclru_checker u_sclru_checker (.*);
